// ===== design/med9_pkg.sv =====
package med9_pkg;

    localparam int TDATA_BITS  = 16;
    localparam int MEDIAN_BITS = 12;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic ahead;
        logic valid;
    } cell_link_t;

endpackage

// ===== design/med9_cell.sv =====
module med9_cell
    import med9_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  cell_link_t             left_link,
    input  logic [SAMPLE_BITS-1:0] left_value,
    output cell_link_t             right_link,
    output logic [SAMPLE_BITS-1:0] value_q,
    output logic [SAMPLE_BITS-1:0] value_next
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   ahead_here;

    assign ahead_here = !valid_reg || (in_sample < value_reg);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end
        if (ctrl.insert && ahead_here) begin
            if (left_link.ahead) begin
                value_next = left_value;
            end else begin
                value_next = in_sample;
            end
            if (!ctrl.clear) begin
                valid_next = left_link.ahead ? left_link.valid : 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign right_link.ahead = ahead_here;
    assign right_link.valid = valid_reg;
    assign value_q          = value_reg;

endmodule

// ===== design/median_of_nine_filter_top.sv =====
// Median-of-nine filter.
// Input stream s_*: one converter sample per transaction in s_tdata[11:0].
// Output stream m_*: one median per window of WINDOW samples in m_tdata[11:0].
// Each accepted sample is inserted in sorted position into a row of WINDOW
// cells in the same cycle, so the block accepts one sample per cycle while
// s_tready is high. The insertion compare in every cell bounds the path.
// The median is registered on the edge that accepts the window's last sample
// and shows on m_tvalid from that edge on; a new window starts with the next
// sample.
// Reset empties the window and drops any pending median.
// While a median waits on a stalled receiver, samples are still taken except
// the one that would complete the next window; s_tready is low only then.
module median_of_nine_filter_top
    import med9_pkg::*;
#(
    parameter int WINDOW      = 9,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [11:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata    // [11:0] median
);

    localparam int COUNT_BITS = $clog2(WINDOW + 1);
    localparam int MID_INDEX  = (WINDOW - 1) / 2;

    logic [COUNT_BITS-1:0]  fill_count_reg;
    logic [COUNT_BITS-1:0]  fill_count_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [TDATA_BITS-1:0]  m_tdata_reg;
    logic [TDATA_BITS-1:0]  m_tdata_next;
    logic                   window_last;
    logic                   s_accept;
    logic [SAMPLE_BITS-1:0] sample;
    logic [MEDIAN_BITS-1:0] median_cut;
    cell_ctrl_t             ctrl;

    cell_link_t             link     [WINDOW+1];
    logic [SAMPLE_BITS-1:0] value_q  [WINDOW];
    logic [SAMPLE_BITS-1:0] value_nx [WINDOW];
    logic [SAMPLE_BITS-1:0] left_val [WINDOW];

    assign sample      = s_tdata[SAMPLE_BITS-1:0];
    assign window_last = (fill_count_reg == COUNT_BITS'(WINDOW - 1));
    assign s_tready    = !(window_last && m_tvalid_reg && !m_tready);
    assign s_accept    = s_tvalid && s_tready;

    assign ctrl.insert = s_accept;
    assign ctrl.clear  = s_accept && window_last;

    assign link[0] = '{ahead: 1'b0, valid: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign left_val[gi] = '0;
            end else begin : g_rest
                assign left_val[gi] = value_q[gi-1];
            end
            med9_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .in_sample  (sample),
                .left_link  (link[gi]),
                .left_value (left_val[gi]),
                .right_link (link[gi+1]),
                .value_q    (value_q[gi]),
                .value_next (value_nx[gi])
            );
        end
        if (SAMPLE_BITS >= MEDIAN_BITS) begin : g_cut
            assign median_cut = value_nx[MID_INDEX][MEDIAN_BITS-1:0];
        end else begin : g_ext
            assign median_cut = MEDIAN_BITS'(value_nx[MID_INDEX]);
        end
    endgenerate

    always_comb begin
        fill_count_next = fill_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept) begin
            if (window_last) begin
                fill_count_next = '0;
                m_tvalid_next   = 1'b1;
                m_tdata_next    = TDATA_BITS'(median_cut);
            end else begin
                fill_count_next = fill_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/med9_checker.sv =====
module med9_checker
    import med9_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled median changed");

    // drop pending result on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("median valid after reset");

    // produce a median only on the edge of an input transaction
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("median without input transaction");

    // stall input only behind a stalled result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind median_of_nine_filter_top med9_checker u_med9_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
module tb;
    import med9_pkg::*;

    localparam int WINDOW_LEN     = 9;
    localparam int MID_POS        = (WINDOW_LEN - 1) / 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    typedef logic [MEDIAN_BITS-1:0] sample_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata   = '0;   // [11:0] sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;          // [11:0] median

    sample_t     window_buf[WINDOW_LEN];
    int unsigned fill_cnt;
    sample_t     median_q[$];
    int unsigned mismatch_cnt;
    int unsigned idle_cycles;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    bit          hold_off_req;

    median_of_nine_filter_top #(
        .WINDOW      (WINDOW_LEN),
        .SAMPLE_BITS (MEDIAN_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Gather a window; on its last sample sort it and queue the middle entry.
    task automatic take_sample(input sample_t smp);
        sample_t sorted[WINDOW_LEN];
        sample_t key;
        int      i;
        int      j;
        window_buf[fill_cnt] = smp;
        fill_cnt++;
        if (fill_cnt == WINDOW_LEN) begin
            fill_cnt = 0;
            sorted = window_buf;
            for (i = 1; i < WINDOW_LEN; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            median_q.push_back(sorted[MID_POS]);
        end
    endtask

    task automatic send_sample(input sample_t smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_BITS-MEDIAN_BITS){1'b0}}, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        take_sample(smp);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: rand_sample = '0;
            1: rand_sample = '1;
            2: rand_sample = sample_t'($urandom_range(15));
            3: rand_sample = sample_t'(4095 - $urandom_range(15));
            4: rand_sample = sample_t'(2048 + $urandom_range(7) - 4);
            default: rand_sample = sample_t'($urandom_range(4095));
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check each median against the oldest prediction; watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected median, expected none, actual %0d",
                             $time, m_tdata[MEDIAN_BITS-1:0]);
                    mismatch_cnt++;
                end else begin
                    if (m_tdata[MEDIAN_BITS-1:0] !== median_q[0]) begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, median_q[0], m_tdata[MEDIAN_BITS-1:0]);
                        mismatch_cnt++;
                    end
                    void'(median_q.pop_front());
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic test_directed_extremes();
        int i;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (i = 0; i < WINDOW_LEN; i++)
            send_sample((i % 2 == 0) ? sample_t'(0) : sample_t'(4095));
        for (i = 0; i < WINDOW_LEN; i++)
            send_sample((i % 2 == 0) ? sample_t'(4095) : sample_t'(0));
        for (i = 0; i < WINDOW_LEN; i++)
            send_sample(sample_t'(1) << (MEDIAN_BITS - 1 - i));
    endtask

    task automatic test_random_windows(input int unsigned n_items,
                                       input int unsigned src_pct,
                                       input int unsigned sink_pct);
        int unsigned i;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (i = 0; i < n_items; i++)
            send_sample(rand_sample());
    endtask

    task automatic test_output_backpressure();
        int i;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b1;
        for (i = 0; i < 4 * WINDOW_LEN; i++)
            send_sample(rand_sample());
    endtask

    initial begin
        fill_cnt       = 0;
        mismatch_cnt   = 0;
        idle_cycles    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_random_windows(150, 0, 0);
        test_random_windows(150, 48, 0);
        test_random_windows(150, 0, 48);
        test_random_windows(150, 28, 28);
        test_output_backpressure();

        s_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
